// ===== design/acvs_pkg.sv =====
package acvs_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         particle_index;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } in_word_t;

  typedef struct packed {
    logic [6:0]         out_index;
    logic signed [31:0] out_position;
    logic signed [31:0] out_velocity;
    logic               out_last;
    logic               out_saturated;
  } out_word_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_COUPLING = 2'd0;
  localparam logic [1:0] REG_DT       = 2'd1;
  localparam logic [1:0] REG_LENGTH   = 2'd2;

  localparam int CFG_DATA_W = 32;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = -32'sh80000000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sh7fffffff) sat32 = S32_MAX;
    else if (x < -66'sh80000000) sat32 = S32_MIN;
    else sat32 = x[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] x);
    ovf32 = (x > 66'sh7fffffff) || (x < -66'sh80000000);
  endfunction

endpackage

// ===== design/anharmonic_chain_verlet_step.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_word   (acvs_pkg::in_word_t)
// out     | out | out_valid/out_ready | out_word  (acvs_pkg::out_word_t)
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// Readout: S_RD then S_RDW per word for n words, longer while out_ready is low.
// Step: position pass, then force pass, then velocity pass;
// a stale step runs one more force pass first. One shared 33x32 multiplier.
// rst resets control state and the config registers, then a clearing pass zeroes
// the position, velocity and acceleration stores; in_ready stays low meanwhile.
// in_ready is high only in idle; out_valid holds with its word until out_ready.
module anharmonic_chain_verlet_step #(
  parameter int MAX_PARTICLES = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  acvs_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output acvs_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [acvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import acvs_pkg::*;

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [31:0] HALF_Q = 32'sd1 <<< (FRACTION_BITS - 1);

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_LOAD  = 15'h0004,
    S_RD    = 15'h0008,
    S_RDW   = 15'h0010,
    S_FINIT = 15'h0020,
    S_FPRE  = 15'h0040,
    S_FRD   = 15'h0080,
    S_FMUL  = 15'h0100,
    S_PRD   = 15'h0200,
    S_PMUL  = 15'h0400,
    S_PWR   = 15'h0800,
    S_VRD   = 15'h1000,
    S_VMUL  = 15'h2000,
    S_VWR   = 15'h4000
  } state_t;

  state_t state;

  logic signed [31:0] qmem [MAX_PARTICLES];
  logic signed [31:0] vmem [MAX_PARTICLES];
  logic signed [31:0] amem [MAX_PARTICLES];
  logic signed [31:0] omem [MAX_PARTICLES];

  logic signed [31:0] coupling;
  logic [24:0]        dt_reg;
  logic [6:0]         len_reg;
  logic               stale;
  logic               sat_seen;
  logic               sat_flag;
  logic               post_force;

  logic [CW-1:0] idx;
  logic [CW-1:0] n_eff;
  logic [2:0]    sub;
  logic [AW-1:0] rd_adr;
  logic signed [31:0] qrd, vrd, ard, ord_q;
  logic signed [31:0] qprev, qnow, qnext;
  logic signed [31:0] t_a, t_b, t_c, t_d, t_e;
  logic signed [31:0] dt_eff;
  in_word_t           in_hold;

  // shared multiplier
  logic signed [32:0] m_a;
  logic signed [31:0] m_b;
  logic [5:0]         m_sh;
  logic signed [64:0] m_p;
  logic signed [65:0] m_r;
  logic signed [31:0] m_q;
  logic               m_o;

  logic signed [32:0] sum_a;
  logic signed [65:0] lap_w, d1_w, d0_w, ds_w, acc_w, pos_w, vel_w;

  always_comb begin
    if (len_reg < 7'd2) n_eff = CW'(2);
    else if ({25'd0, len_reg} > MAX_PARTICLES) n_eff = CW'(MAX_PARTICLES);
    else n_eff = CW'(len_reg);
    dt_eff = ({7'd0, dt_reg} > ONE_Q) ? ONE_Q : $signed({7'd0, dt_reg});
  end

  assign sum_a = 33'(ord_q) + 33'(ard);
  assign lap_w = 66'(qnext) - 66'(qnow) - 66'(qnow) + 66'(qprev);
  assign d1_w  = 66'(qnext) - 66'(qnow);
  assign d0_w  = 66'(qnow) - 66'(qprev);
  assign ds_w  = 66'(t_e) - 66'(m_q);
  assign acc_w = 66'(t_c) + 66'(m_q);
  assign pos_w = 66'(qrd) + 66'(t_a) + 66'(t_c);
  assign vel_w = 66'(vrd) + 66'(t_a);

  always_comb begin
    if (state == S_VMUL) begin
      m_a = sum_a;
      m_b = dt_eff;
      m_sh = 6'(FRACTION_BITS + 1);
    end else begin
      m_a = {t_a[31], t_a};
      m_b = t_b;
      m_sh = 6'(FRACTION_BITS);
    end
    m_p = m_a * m_b;
    m_r = (66'(m_p) + (66'sd1 <<< (m_sh - 6'd1))) >>> m_sh;
    m_q = sat32(m_r);
    m_o = ovf32(m_r);
  end

  assign in_ready = (state == S_IDLE);
  assign rd_adr   = (state == S_FRD) ? AW'(idx + CW'(1)) : idx[AW-1:0];

  always_ff @(posedge clk) begin
    qrd   <= qmem[rd_adr];
    vrd   <= vmem[rd_adr];
    ard   <= amem[rd_adr];
    ord_q <= omem[rd_adr];
  end

  logic               q_we, v_we, a_we, o_we;
  logic signed [31:0] q_wd, v_wd, a_wd;
  logic [AW-1:0]      w_adr;

  always_ff @(posedge clk) begin
    if (q_we) qmem[w_adr] <= q_wd;
    if (v_we) vmem[w_adr] <= v_wd;
    if (a_we) amem[w_adr] <= a_wd;
    if (o_we) omem[w_adr] <= ard;
  end

  always_comb begin
    q_we = 1'b0; v_we = 1'b0; a_we = 1'b0; o_we = 1'b0;
    q_wd = in_hold.load_position; v_wd = in_hold.load_velocity; a_wd = '0;
    w_adr = idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        q_we = 1'b1; v_we = 1'b1; a_we = 1'b1; q_wd = '0; v_wd = '0;
      end
      S_LOAD: begin
        w_adr = AW'(in_hold.particle_index - 7'd1);
        q_we = 1'b1; v_we = 1'b1;
      end
      S_FMUL: if (sub == 3'd4) begin
        a_we = 1'b1;
        a_wd = sat32(acc_w);
      end
      S_PWR: begin
        q_we = 1'b1;
        o_we = 1'b1;
        q_wd = sat32(pos_w);
      end
      S_VWR: begin
        v_we = 1'b1;
        v_wd = sat32(vel_w);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      sub <= '0;
      coupling <= 32'sd1 <<< (FRACTION_BITS - 2);
      dt_reg <= 25'(((64'd1 << FRACTION_BITS) * 5 + 50) / 100);
      len_reg <= 7'd32;
      stale <= 1'b1;
      sat_seen <= 1'b0;
      sat_flag <= 1'b0;
      out_valid <= 1'b0;
      post_force <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COUPLING: coupling <= cfg_data;
          REG_DT:       dt_reg <= cfg_data[24:0];
          REG_LENGTH:   len_reg <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cfg_we && (cfg_index == REG_COUPLING || cfg_index == REG_LENGTH))
        stale <= 1'b1;
      else if (state == S_LOAD)
        stale <= 1'b1;
      else if (state == S_IDLE && in_valid && in_word.action == ACT_STEP)
        stale <= 1'b0;
      if (state == S_RDW && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (idx == CW'(MAX_PARTICLES - 1)) begin
            idx <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_hold <= in_word;
            idx <= '0;
            sub <= '0;
            case (in_word.action)
              ACT_LOAD: begin
                if (in_word.particle_index >= 7'd1 &&
                    {25'd0, in_word.particle_index} <= 32'(n_eff)) begin
                  state <= S_LOAD;
                end
              end
              ACT_STEP: begin
                post_force <= 1'b0;
                if (stale) state <= S_FINIT;
                else state <= S_PRD;
              end
              ACT_READ: begin
                sat_flag <= sat_seen;
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_LOAD: state <= S_IDLE;
        S_RD: state <= S_RDW;
        S_RDW: begin
          if (!out_valid || out_ready) begin
            out_word.out_index <= 7'(idx + CW'(1));
            out_word.out_position <= qrd;
            out_word.out_velocity <= vrd;
            out_word.out_last <= (idx == n_eff - CW'(1));
            out_word.out_saturated <= sat_flag;
            if (idx == n_eff - CW'(1)) begin
              sat_seen <= 1'b0;
              idx <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + CW'(1);
              state <= S_RD;
            end
          end
        end
        // force pass: slide a window of three positions along the chain
        S_FINIT: state <= S_FPRE;
        S_FPRE: begin
          qnow <= '0;
          qnext <= qrd;
          state <= S_FRD;
        end
        S_FRD: begin
          sub <= '0;
          state <= S_FMUL;
        end
        S_FMUL: begin
          sub <= sub + 3'd1;
          case (sub)
            3'd0: begin
              qprev <= qnow;
              qnow <= qnext;
              qnext <= (idx + CW'(1) < n_eff) ? qrd : 32'sd0;
            end
            3'd1: begin
              t_c <= sat32(lap_w);
              t_a <= sat32(d1_w);
              t_b <= sat32(d1_w);
              t_d <= sat32(d0_w);
              sat_seen <= sat_seen | ovf32(lap_w) | ovf32(d1_w) | ovf32(d0_w);
            end
            3'd2: begin
              t_e <= m_q;
              t_a <= t_d;
              t_b <= t_d;
              sat_seen <= sat_seen | m_o;
            end
            3'd3: begin
              t_a <= coupling;
              t_b <= sat32(ds_w);
              sat_seen <= sat_seen | m_o | ovf32(ds_w);
            end
            3'd4: begin
              sat_seen <= sat_seen | m_o | ovf32(acc_w);
              if (idx == n_eff - CW'(1)) begin
                idx <= '0;
                if (post_force) state <= S_VRD;
                else state <= S_PRD;
              end else begin
                idx <= idx + CW'(1);
                state <= S_FRD;
              end
            end
            default: ;
          endcase
        end
        // position pass
        S_PRD: begin
          sub <= '0;
          state <= S_PMUL;
        end
        S_PMUL: begin
          sub <= sub + 3'd1;
          case (sub)
            3'd0: begin t_a <= ard; t_b <= dt_eff; end
            3'd1: begin t_a <= m_q; sat_seen <= sat_seen | m_o; end
            3'd2: begin t_a <= m_q; t_b <= HALF_Q; sat_seen <= sat_seen | m_o; end
            3'd3: begin
              t_c <= m_q; t_a <= vrd; t_b <= dt_eff;
              sat_seen <= sat_seen | m_o;
            end
            3'd4: begin t_a <= m_q; sat_seen <= sat_seen | m_o; state <= S_PWR; end
            default: ;
          endcase
        end
        S_PWR: begin
          sat_seen <= sat_seen | ovf32(pos_w);
          if (idx == n_eff - CW'(1)) begin
            idx <= '0;
            post_force <= 1'b1;
            state <= S_FINIT;
          end else begin
            idx <= idx + CW'(1);
            state <= S_PRD;
          end
        end
        // velocity pass: omem holds the old accelerations
        S_VRD: state <= S_VMUL;
        S_VMUL: begin
          t_a <= m_q;
          sat_seen <= sat_seen | m_o;
          state <= S_VWR;
        end
        S_VWR: begin
          sat_seen <= sat_seen | ovf32(vel_w);
          if (idx == n_eff - CW'(1)) begin
            idx <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
            state <= S_VRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word));

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state));

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready);

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_last |-> out_word.out_index == 7'(n_eff));

endmodule
